// ===== design/lrc_pkg.sv =====
// Shared types, constants and clamp function for the line rasterizer.
package lrc_pkg;

   localparam int COORD_W   = 6;
   localparam int CFG_W     = 7;
   localparam int ERR_W     = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_BUFFER_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_BUFFER_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] BUFFER_SIZE_RESET = 7'd64;

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
   } segment_type;

   typedef struct packed {
      coord_type major_start;
      coord_type major_stop;
      coord_type minor_start;
      coord_type minor_delta;
      coord_type span;
      logic      major_up;
      logic      minor_up;
      logic      x_major;
   } walk_init_type;

   typedef struct packed {
      logic load;
      logic advance;
   } step_ctrl_type;

   typedef struct packed {
      coord_type major;
      coord_type major_stop;
      coord_type minor;
      logic      major_up;
      logic      x_major;
      logic      last;
   } step_status_type;

   function automatic coord_type clamp_coord(input coord_type v, input logic [CFG_W-1:0] size);
      logic [CFG_W-1:0] lim;
      coord_type        res;
      lim = size - CFG_W'(1);
      if (size == '0) begin
         res = '0;
      end else if ({1'b0, v} >= size) begin
         res = lim[COORD_W-1:0];
      end else begin
         res = v;
      end
      return res;
   endfunction

endpackage

// ===== design/lrc_setup.sv =====
// Walk setup: picks major axis, start, stop, directions and error increments.
module lrc_setup (
   input  lrc_pkg::segment_type   seg,
   output lrc_pkg::walk_init_type init
);
   import lrc_pkg::*;

   coord_type dx_abs;
   coord_type dy_abs;
   logic      x_first;
   logic      y_first;

   always_comb begin
      dx_abs  = (seg.x_start > seg.x_end) ? seg.x_start - seg.x_end : seg.x_end - seg.x_start;
      dy_abs  = (seg.y_start > seg.y_end) ? seg.y_start - seg.y_end : seg.y_end - seg.y_start;
      x_first = seg.x_start < seg.x_end;
      y_first = seg.y_start < seg.y_end;
      init    = '0;
      if (seg.x_start == seg.x_end) begin
         // vertical or single point: walk y from the first endpoint
         init.major_start = seg.y_start;
         init.major_stop  = seg.y_end;
         init.major_up    = seg.y_end >= seg.y_start;
         init.minor_start = seg.x_start;
         init.minor_delta = '0;
         init.span        = dy_abs;
         init.x_major     = 1'b0;
      end else if (seg.y_start == seg.y_end) begin
         init.major_start = seg.x_start;
         init.major_stop  = seg.x_end;
         init.major_up    = seg.x_end > seg.x_start;
         init.minor_start = seg.y_start;
         init.minor_delta = '0;
         init.span        = dx_abs;
         init.x_major     = 1'b1;
      end else if (dy_abs <= dx_abs) begin
         init.major_start = x_first ? seg.x_start : seg.x_end;
         init.major_stop  = x_first ? seg.x_end : seg.x_start;
         init.major_up    = 1'b1;
         init.minor_start = x_first ? seg.y_start : seg.y_end;
         init.minor_up    = (seg.y_end > seg.y_start) == x_first;
         init.minor_delta = dy_abs;
         init.span        = dx_abs;
         init.x_major     = 1'b1;
      end else begin
         init.major_start = y_first ? seg.y_start : seg.y_end;
         init.major_stop  = y_first ? seg.y_end : seg.y_start;
         init.major_up    = 1'b1;
         init.minor_start = y_first ? seg.x_start : seg.x_end;
         init.minor_up    = (seg.x_end > seg.x_start) == y_first;
         init.minor_delta = dx_abs;
         init.span        = dy_abs;
         init.x_major     = 1'b0;
      end
   end

endmodule

// ===== design/lrc_stepper.sv =====
// Cell stepper: major counter, minor coordinate and shared error accumulator.
module lrc_stepper (
   input  logic                    clock,
   input  lrc_pkg::step_ctrl_type  ctrl,
   input  lrc_pkg::walk_init_type  init,
   output lrc_pkg::step_status_type status
);
   import lrc_pkg::*;

   coord_type               major_ff,  major_in;
   coord_type               stop_ff,   stop_in;
   coord_type               minor_ff,  minor_in;
   coord_type               delta_ff,  delta_in;
   coord_type               span_ff,   span_in;
   logic                    up_ff,     up_in;
   logic                    minor_up_ff, minor_up_in;
   logic                    x_major_ff, x_major_in;
   logic signed [ERR_W-1:0] err_ff,    err_in;
   logic signed [ERR_W-1:0] err_sum;
   logic signed [ERR_W-1:0] span_err;
   logic signed [ERR_W:0]   err_twice;
   logic                    minor_step;

   always_comb begin
      span_err   = $signed({{(ERR_W-COORD_W){1'b0}}, span_ff});
      err_sum    = err_ff + $signed({{(ERR_W-COORD_W){1'b0}}, delta_ff});
      err_twice  = {err_sum, 1'b0};
      minor_step = err_twice >= $signed({{(ERR_W+1-COORD_W){1'b0}}, span_ff});

      major_in    = major_ff;
      stop_in     = stop_ff;
      minor_in    = minor_ff;
      delta_in    = delta_ff;
      span_in     = span_ff;
      up_in       = up_ff;
      minor_up_in = minor_up_ff;
      x_major_in  = x_major_ff;
      err_in      = err_ff;
      if (ctrl.load) begin
         major_in    = init.major_start;
         stop_in     = init.major_stop;
         minor_in    = init.minor_start;
         delta_in    = init.minor_delta;
         span_in     = init.span;
         up_in       = init.major_up;
         minor_up_in = init.minor_up;
         x_major_in  = init.x_major;
         err_in      = '0;
      end else if (ctrl.advance) begin
         major_in = up_ff ? major_ff + COORD_W'(1) : major_ff - COORD_W'(1);
         if (minor_step) begin
            minor_in = minor_up_ff ? minor_ff + COORD_W'(1) : minor_ff - COORD_W'(1);
            err_in   = err_sum - span_err;
         end else begin
            err_in = err_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      major_ff    <= major_in;
      stop_ff     <= stop_in;
      minor_ff    <= minor_in;
      delta_ff    <= delta_in;
      span_ff     <= span_in;
      up_ff       <= up_in;
      minor_up_ff <= minor_up_in;
      x_major_ff  <= x_major_in;
      err_ff      <= err_in;
   end

   assign status.major      = major_ff;
   assign status.major_stop = stop_ff;
   assign status.minor      = minor_ff;
   assign status.major_up   = up_ff;
   assign status.x_major    = x_major_ff;
   assign status.last       = major_ff == stop_ff;

endmodule

// ===== design/line_rasterizer_clamped.sv =====
// Top level: segment in, clamped grid cells out, one per cycle while rsp is not stalled.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | x_start, y_start, x_end, y_end
//   rsp     | out       | rsp_valid/rsp_ready  | cell_x, cell_y, last_cell
//   csr     | in        | csr_write_en         | csr_index, csr_wdata
//
// A segment of N cells is accepted, set up, then walked one cell per cycle
// while rsp is not stalled, from the stepper's error accumulator; N is at most GRID_SIZE.
// One segment is in flight at a time; req_ready is high only between segments.
// Reset clears the sequencer, the output valid and sets both buffer sizes to 64.
// A stalled rsp holds the stepper; the next request is taken while the final
// cell still waits in the output register.
module line_rasterizer_clamped #(
   parameter int GRID_SIZE = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [lrc_pkg::COORD_W-1:0]     req_x_start,
   input  logic [lrc_pkg::COORD_W-1:0]     req_y_start,
   input  logic [lrc_pkg::COORD_W-1:0]     req_x_end,
   input  logic [lrc_pkg::COORD_W-1:0]     req_y_end,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [lrc_pkg::COORD_W-1:0]     rsp_cell_x,
   output logic [lrc_pkg::COORD_W-1:0]     rsp_cell_y,
   output logic                            rsp_last_cell,
   input  logic                            csr_write_en,
   input  logic [lrc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lrc_pkg::CFG_W-1:0]       csr_wdata
);
   import lrc_pkg::*;

   localparam coord_type COORD_MAX = COORD_W'(GRID_SIZE - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   segment_type      seg_ff, seg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   coord_type        cell_x_ff, cell_x_in;
   coord_type        cell_y_ff, cell_y_in;
   logic             last_ff, last_in;

   walk_init_type    init;
   step_ctrl_type    ctrl;
   step_status_type  status;
   logic             req_accept;
   logic             out_free;
   coord_type        raw_x;
   coord_type        raw_y;

   function automatic coord_type sat_coord(input coord_type v);
      return (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   lrc_setup u_setup (
      .seg  (seg_ff),
      .init (init)
   );

   lrc_stepper u_stepper (
      .clock  (clock),
      .ctrl   (ctrl),
      .init   (init),
      .status (status)
   );

   assign req_ready  = state_ff == ST_IDLE;
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign raw_x      = status.x_major ? status.major : status.minor;
   assign raw_y      = status.x_major ? status.minor : status.major;

   always_comb begin
      state_in     = state_ff;
      seg_in       = seg_ff;
      ctrl         = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cell_x_in    = cell_x_ff;
      cell_y_in    = cell_y_ff;
      last_in      = last_ff;
      width_in     = width_ff;
      height_in    = height_ff;

      if (csr_write_en) begin
         case (csr_index)
            REG_BUFFER_WIDTH:  width_in  = csr_wdata;
            REG_BUFFER_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               seg_in.x_start = sat_coord(req_x_start);
               seg_in.y_start = sat_coord(req_y_start);
               seg_in.x_end   = sat_coord(req_x_end);
               seg_in.y_end   = sat_coord(req_y_end);
               state_in       = ST_SETUP;
            end
         end
         ST_SETUP: begin
            ctrl.load = 1'b1;
            state_in  = ST_WALK;
         end
         ST_WALK: begin
            if (out_free) begin
               ctrl.advance = 1'b1;
               rsp_valid_in = 1'b1;
               cell_x_in    = clamp_coord(raw_x, width_ff);
               cell_y_in    = clamp_coord(raw_y, height_ff);
               last_in      = status.last;
               if (status.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         width_ff     <= BUFFER_SIZE_RESET;
         height_ff    <= BUFFER_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff    <= seg_in;
      cell_x_ff <= cell_x_in;
      cell_y_ff <= cell_y_in;
      last_ff   <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_x    = cell_x_ff;
   assign rsp_cell_y    = cell_y_ff;
   assign rsp_last_cell = last_ff;

   a_accept_to_setup: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_SETUP && !req_ready)
      else $error("accepted request did not enter setup");

   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && out_free && status.last) |=> state_ff == ST_IDLE && rsp_last_cell)
      else $error("final cell did not end the walk");

   a_walk_toward_stop: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> (status.major == status.major_stop)
         || (status.major_up && status.major < status.major_stop)
         || (!status.major_up && status.major > status.major_stop))
      else $error("major counter passed its stop");

endmodule
